[rtl/avz_pkg.sv]
// ----------------------------------------------------------------------------
// avz_pkg - shared constants for the velocity integrator
// Field widths, fixed-point scale factors, divider sizing and register map.
// ----------------------------------------------------------------------------
`default_nettype none

package avz_pkg;

    // field widths
    localparam int SAMPLE_W     = 16;
    localparam int MS_W         = 10;
    localparam int VEL_W        = 40;
    localparam int DEAD_W       = 10;
    localparam int STILL_BAND_W = 12;
    localparam int STILL_LIM_W  = 10;
    localparam int SPEED_LIM_W  = 31;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STILL_BAND  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STILL_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 2'd3;

    localparam logic [DEAD_W-1:0]      DEAD_BAND_RST   = 10'd77;
    localparam logic [STILL_BAND_W-1:0] STILL_BAND_RST = 12'd256;
    localparam logic [STILL_LIM_W-1:0] STILL_LIMIT_RST = 10'd100;
    localparam logic [SPEED_LIM_W-1:0] SPEED_LIMIT_RST = 31'd512000;

    // bias calibration
    localparam int CAL_SAMPLES = 100;
    localparam int CAL_CNT_W   = 7;
    localparam int CAL_SUM_W   = 24;
    localparam int CAL_HALF    = CAL_SAMPLES / 2;

    // accel = round(diff * 49 / 40), 1/256 m/s^2 per lsb
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int ACCEL_NUM  = 49;
    localparam int ACCEL_DEN  = 40;
    localparam int ACCEL_HALF = ACCEL_DEN / 2;
    localparam int MAG_W      = 17;
    localparam int ACCEL_W    = MAG_W + 1;
    localparam int PROD_W     = ACCEL_W + MS_W + 1;

    // signed numerator ahead of the divider
    localparam int NUM_W = 24;

    // reciprocal divider: q = (n * ceil(2^RECIP_SHIFT / d)) >> RECIP_SHIFT,
    // exact for n below 2^DIV_W and any divisor below 2^(RECIP_SHIFT - DIV_W)
    localparam int DIV_W       = 22;
    localparam int RECIP_SHIFT = 29;
    localparam int RECIP_W     = 30;
    localparam int DIV_PROD_W  = DIV_W + RECIP_W;
    localparam int RECIP_ONE   = 1 << RECIP_SHIFT;

    localparam logic [RECIP_W-1:0] CAL_RECIP =
        RECIP_W'((RECIP_ONE + CAL_SAMPLES - 1) / CAL_SAMPLES);
    localparam logic [RECIP_W-1:0] ACCEL_RECIP =
        RECIP_W'((RECIP_ONE + ACCEL_DEN - 1) / ACCEL_DEN);

    // velocity saturation bounds
    localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

endpackage

`default_nettype wire

[rtl/avz_div.sv]
// ----------------------------------------------------------------------------
// avz_div - multi-cycle unsigned divider
// Divides a DIV_W-bit dividend by a constant through its scaled reciprocal:
// the operands are registered, then one multiply; done pulses for one cycle
// as the product register is loaded, with the quotient valid.
// ----------------------------------------------------------------------------
`default_nettype none

module avz_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [avz_pkg::DIV_W-1:0]   dividend,
    input  wire logic [avz_pkg::RECIP_W-1:0] recip,
    output logic                             done,
    output logic [avz_pkg::DIV_W-1:0]        quotient
);
    import avz_pkg::*;

    logic                  mul_go_reg;
    logic                  done_reg;
    logic [DIV_W-1:0]      op_reg;
    logic [RECIP_W-1:0]    recip_reg;
    logic [DIV_PROD_W-1:0] prod_reg;

    // operand capture, then the reciprocal multiply
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_go_reg <= 1'b0;
            done_reg   <= 1'b0;
            op_reg     <= '0;
            recip_reg  <= '0;
            prod_reg   <= '0;
        end
        else
        begin
            mul_go_reg <= start;
            done_reg   <= mul_go_reg;
            if (start)
            begin
                op_reg    <= dividend;
                recip_reg <= recip;
            end
            if (mul_go_reg)
            begin
                prod_reg <= DIV_PROD_W'(op_reg) * DIV_PROD_W'(recip_reg);
            end
        end
    end

    assign done     = done_reg;
    assign quotient = prod_reg[RECIP_SHIFT +: DIV_W];

endmodule

`default_nettype wire

[rtl/accel_velocity_integrator_zupt.sv]
// ----------------------------------------------------------------------------
// accel_velocity_integrator_zupt - accelerometer velocity integrator with
// zero-velocity update
// Removes bias from X samples, scales to m/s^2, integrates into a saturating
// velocity and clears it after a run of stationary samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries accel_sample and elapsed_ms.
//   Output channel (out_valid/out_ready) returns one item per input item:
//   velocity, over_limit, calibrating and zeroed.
//   The first CAL_SAMPLES items after reset are averaged into the bias and
//   return the held velocity with calibrating set.
//   A calibration item goes from acceptance straight to the response step;
//   the last calibration item first runs the prep and divide steps, and a
//   normal item the scale, prep, divide, multiply and accumulate steps.
//   Only one item is in flight; in_ready rises at the edge that loads the
//   result into the output register, so a new item is taken only after that.
//   If the receiver stalls, the result waits in the output register and the
//   next item is still accepted and worked on; it waits to be loaded until
//   the previous result is taken.
//   Reset clears the bias, calibration, velocity and stationary count, and
//   loads the default register values. Configuration is written through
//   cfg_we/cfg_index/cfg_data while the block is idle; the user must keep
//   to that, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_velocity_integrator_zupt (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [avz_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [avz_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [avz_pkg::SAMPLE_W-1:0]  accel_sample,
    input  wire logic [avz_pkg::MS_W-1:0]             elapsed_ms,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [avz_pkg::VEL_W-1:0]          velocity,
    output logic                                      over_limit,
    output logic                                      calibrating,
    output logic                                      zeroed
);
    import avz_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_PREP,
        ST_DIVIDE,
        ST_MUL,
        ST_ACCUM,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [DEAD_W-1:0]       dead_band_reg, dead_band_next;
    logic [STILL_BAND_W-1:0] still_band_reg, still_band_next;
    logic [STILL_LIM_W-1:0]  still_limit_reg, still_limit_next;
    logic [SPEED_LIM_W-1:0]  speed_limit_reg, speed_limit_next;

    // persistent state
    logic signed [SAMPLE_W-1:0]  bias_reg, bias_next;
    logic signed [CAL_SUM_W-1:0] cal_sum_reg, cal_sum_next;
    logic [CAL_CNT_W-1:0]        cal_count_reg, cal_count_next;
    logic signed [VEL_W-1:0]     speed_reg, speed_next;
    logic [STILL_LIM_W-1:0]      still_count_reg, still_count_next;

    // per-item working registers
    logic                        cal_mode_reg, cal_mode_next;
    logic [MS_W-1:0]             ms_reg, ms_next;
    logic signed [DIFF_W-1:0]    diff_reg, diff_next;
    logic signed [NUM_W-1:0]     num_reg, num_next;
    logic signed [ACCEL_W-1:0]   accel_reg, accel_next;
    logic [MAG_W-1:0]            mag_reg, mag_next;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    logic                        zero_hit_reg, zero_hit_next;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic signed [VEL_W-1:0]     velocity_reg, velocity_next;
    logic                        over_limit_reg, over_limit_next;
    logic                        calibrating_reg, calibrating_next;
    logic                        zeroed_reg, zeroed_next;

    // divider hookup
    logic                        div_start;
    logic                        div_done;
    logic [DIV_W-1:0]            div_quotient;
    logic [DIV_W-1:0]            div_dividend;
    logic [RECIP_W-1:0]          div_recip;
    logic                        num_neg;
    logic [NUM_W-1:0]            num_mag;

    // combinational helpers
    logic signed [CAL_SUM_W-1:0] cal_sum_add;
    logic [CAL_CNT_W-1:0]        cal_count_inc;
    logic [MAG_W-1:0]            q_mag;
    logic signed [VEL_W:0]       vel_sum;
    logic signed [VEL_W-1:0]     vel_sat;
    logic                        stationary;
    logic [STILL_LIM_W-1:0]      still_new;
    logic [VEL_W-1:0]            speed_abs;
    logic                        speed_over;

    // dividend is |num| plus half the divisor for round half away from zero
    assign num_neg      = num_reg[NUM_W-1];
    assign num_mag      = num_neg ? NUM_W'(-num_reg) : NUM_W'(num_reg);
    assign div_recip    = cal_mode_reg ? CAL_RECIP : ACCEL_RECIP;
    assign div_dividend = DIV_W'(num_mag + (cal_mode_reg ? NUM_W'(CAL_HALF)
                                                         : NUM_W'(ACCEL_HALF)));

    avz_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .recip    (div_recip),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // over-limit compare on the settled velocity
    assign speed_abs  = speed_reg[VEL_W-1] ? VEL_W'(-speed_reg) : VEL_W'(speed_reg);
    assign speed_over = (speed_abs >= VEL_W'(speed_limit_reg));

    // sequencer and datapath next values
    always_comb
    begin
        state_next       = state_reg;
        dead_band_next   = dead_band_reg;
        still_band_next  = still_band_reg;
        still_limit_next = still_limit_reg;
        speed_limit_next = speed_limit_reg;
        bias_next        = bias_reg;
        cal_sum_next     = cal_sum_reg;
        cal_count_next   = cal_count_reg;
        speed_next       = speed_reg;
        still_count_next = still_count_reg;
        cal_mode_next    = cal_mode_reg;
        ms_next          = ms_reg;
        diff_next        = diff_reg;
        num_next         = num_reg;
        accel_next       = accel_reg;
        mag_next         = mag_reg;
        prod_next        = prod_reg;
        zero_hit_next    = zero_hit_reg;
        out_valid_next   = out_valid_reg;
        velocity_next    = velocity_reg;
        over_limit_next  = over_limit_reg;
        calibrating_next = calibrating_reg;
        zeroed_next      = zeroed_reg;
        div_start        = 1'b0;

        cal_sum_add   = cal_sum_reg + CAL_SUM_W'(accel_sample);
        cal_count_inc = cal_count_reg + 1'b1;
        q_mag         = div_quotient[MAG_W-1:0];
        vel_sum       = (VEL_W+1)'(speed_reg) + (VEL_W+1)'(prod_reg);
        vel_sat       = vel_sum[VEL_W-1:0];
        stationary    = (mag_reg < MAG_W'(still_band_reg));
        still_new     = stationary ? still_count_reg + 1'b1 : '0;

        // configuration writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEAD_BAND:   dead_band_next   = cfg_data[DEAD_W-1:0];
                REG_STILL_BAND:  still_band_next  = cfg_data[STILL_BAND_W-1:0];
                REG_STILL_LIMIT: still_limit_next = cfg_data[STILL_LIM_W-1:0];
                REG_SPEED_LIMIT: speed_limit_next = cfg_data[SPEED_LIM_W-1:0];
                default:         dead_band_next   = dead_band_reg;
            endcase
        end

        // result taken by receiver
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ms_next       = elapsed_ms;
                    zero_hit_next = 1'b0;
                    if (cal_count_reg < CAL_CNT_W'(CAL_SAMPLES))
                    begin
                        cal_mode_next  = 1'b1;
                        cal_sum_next   = cal_sum_add;
                        cal_count_next = cal_count_inc;
                        num_next       = NUM_W'(cal_sum_add);
                        if (cal_count_inc >= CAL_CNT_W'(CAL_SAMPLES))
                        begin
                            state_next = ST_PREP;
                        end
                        else
                        begin
                            state_next = ST_RESP;
                        end
                    end
                    else
                    begin
                        cal_mode_next = 1'b0;
                        diff_next     = DIFF_W'(accel_sample) - DIFF_W'(bias_reg);
                        state_next    = ST_SCALE;
                    end
                end
            end

            // diff * 49 in units of 1/40 of 1/256 m/s^2
            ST_SCALE:
            begin
                num_next   = NUM_W'(diff_reg) * $signed(NUM_W'(ACCEL_NUM));
                state_next = ST_PREP;
            end

            ST_PREP:
            begin
                div_start  = 1'b1;
                state_next = ST_DIVIDE;
            end

            // wait for the shared divider
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    if (cal_mode_reg)
                    begin
                        bias_next  = num_neg ? -div_quotient[SAMPLE_W-1:0]
                                             : div_quotient[SAMPLE_W-1:0];
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        if (q_mag < MAG_W'(dead_band_reg))
                        begin
                            mag_next   = '0;
                            accel_next = '0;
                        end
                        else
                        begin
                            mag_next   = q_mag;
                            accel_next = num_neg ? -ACCEL_W'(q_mag) : ACCEL_W'(q_mag);
                        end
                        state_next = ST_MUL;
                    end
                end
            end

            // velocity step = accel * ms
            ST_MUL:
            begin
                prod_next  = PROD_W'(accel_reg) * PROD_W'($signed({1'b0, ms_reg}));
                state_next = ST_ACCUM;
            end

            // saturating integrate and stationary count
            ST_ACCUM:
            begin
                if (vel_sum[VEL_W] != vel_sum[VEL_W-1])
                begin
                    vel_sat = vel_sum[VEL_W] ? VEL_MIN : VEL_MAX;
                end
                if (still_new >= still_limit_reg)
                begin
                    speed_next       = '0;
                    still_count_next = '0;
                    zero_hit_next    = 1'b1;
                end
                else
                begin
                    speed_next       = vel_sat;
                    still_count_next = still_new;
                end
                state_next = ST_RESP;
            end

            // load the output register once it is free
            ST_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    velocity_next    = speed_reg;
                    over_limit_next  = !cal_mode_reg && speed_over;
                    calibrating_next = cal_mode_reg;
                    zeroed_next      = !cal_mode_reg && zero_hit_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            dead_band_reg   <= DEAD_BAND_RST;
            still_band_reg  <= STILL_BAND_RST;
            still_limit_reg <= STILL_LIMIT_RST;
            speed_limit_reg <= SPEED_LIMIT_RST;
            bias_reg        <= '0;
            cal_sum_reg     <= '0;
            cal_count_reg   <= '0;
            speed_reg       <= '0;
            still_count_reg <= '0;
            cal_mode_reg    <= 1'b0;
            ms_reg          <= '0;
            diff_reg        <= '0;
            num_reg         <= '0;
            accel_reg       <= '0;
            mag_reg         <= '0;
            prod_reg        <= '0;
            zero_hit_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            velocity_reg    <= '0;
            over_limit_reg  <= 1'b0;
            calibrating_reg <= 1'b0;
            zeroed_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            dead_band_reg   <= dead_band_next;
            still_band_reg  <= still_band_next;
            still_limit_reg <= still_limit_next;
            speed_limit_reg <= speed_limit_next;
            bias_reg        <= bias_next;
            cal_sum_reg     <= cal_sum_next;
            cal_count_reg   <= cal_count_next;
            speed_reg       <= speed_next;
            still_count_reg <= still_count_next;
            cal_mode_reg    <= cal_mode_next;
            ms_reg          <= ms_next;
            diff_reg        <= diff_next;
            num_reg         <= num_next;
            accel_reg       <= accel_next;
            mag_reg         <= mag_next;
            prod_reg        <= prod_next;
            zero_hit_reg    <= zero_hit_next;
            out_valid_reg   <= out_valid_next;
            velocity_reg    <= velocity_next;
            over_limit_reg  <= over_limit_next;
            calibrating_reg <= calibrating_next;
            zeroed_reg      <= zeroed_next;
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign velocity    = velocity_reg;
    assign over_limit  = over_limit_reg;
    assign calibrating = calibrating_reg;
    assign zeroed      = zeroed_reg;

`ifndef SYNTH
    // one item in flight: ready drops right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an item is in flight");

    // calibration results carry no flags
    a_cal_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && calibrating |-> !over_limit && !zeroed)
        else $error("calibration item with flags set");

    // a zero-velocity update really clears the velocity
    a_zeroed_vel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zeroed |-> velocity == '0)
        else $error("zeroed item with nonzero velocity");

    // calibration count never runs past the sample total
    a_cal_count: assert property (@(posedge clk) disable iff (!rst_n)
        cal_count_reg <= CAL_CNT_W'(CAL_SAMPLES))
        else $error("calibration count overrun");

    // divider only started from its prep step, and finishes while waited on
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIVIDE)
        else $error("divider finished outside the divide step");
`endif

endmodule

`default_nettype wire

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top - testbench for accel_velocity_integrator_zupt
// Calibrates the bias to a known value, then runs directed items at the dead
// band, still band, rounding and speed-limit edges, a run of full-scale
// items and random items under several register settings. A scoreboard
// predicts every result and checks each one on the output handshake, while
// the sender idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    import avz_pkg::*;

    localparam int     CYCLE_LIMIT = 2_000_000;
    localparam int     DRAIN_CYCLES = 20;
    localparam int     RANDOM_PHASES = 6;
    localparam int     RANDOM_ITEMS = 300;
    // calibration sum ending in an exact half, so the bias rounds away to -30000
    localparam int     CAL_TARGET = -2999950;
    localparam longint VEL_TOP = longint'(VEL_MAX);
    localparam longint VEL_BOTTOM = longint'(VEL_MIN);

    typedef struct packed {
        logic signed [VEL_W-1:0] velocity;
        logic                    over_limit;
        logic                    calibrating;
        logic                    zeroed;
    } vel_result_t;

    // predicts the integrator and checks its results in order
    class zupt_tracker;
        int          dead_band;
        int          still_band;
        int          still_limit;
        int          speed_limit;
        int          bias;
        int          cal_sum;
        int          cal_count;
        longint      speed;
        int          still_count;
        vel_result_t pending_results[$];
        int          errors;
        int          items;
        int          checked;
        int          zero_events;
        int          saturated;

        function new();
            dead_band   = DEAD_BAND_RST;
            still_band  = STILL_BAND_RST;
            still_limit = STILL_LIMIT_RST;
            speed_limit = SPEED_LIMIT_RST;
            bias        = 0;
            cal_sum     = 0;
            cal_count   = 0;
            speed       = 0;
            still_count = 0;
            errors      = 0;
            items       = 0;
            checked     = 0;
            zero_events = 0;
            saturated   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_DEAD_BAND:   dead_band = int'(data[DEAD_W-1:0]);
                REG_STILL_BAND:  still_band = int'(data[STILL_BAND_W-1:0]);
                REG_STILL_LIMIT: still_limit = int'(data[STILL_LIM_W-1:0]);
                REG_SPEED_LIMIT: speed_limit = int'(data[SPEED_LIM_W-1:0]);
                default:         ;
            endcase
        endfunction

        // division rounded half away from zero
        function int round_half_away(int num, int den);
            int mag;
            int q;
            mag = (num < 0) ? -num : num;
            q = (mag + den / 2) / den;
            return (num < 0) ? -q : q;
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] sample, logic [MS_W-1:0] ms);
            vel_result_t r;
            int          diff;
            int          accel;
            int          mag;
            longint      v;
            longint      av;
            r = '0;
            items++;
            if (cal_count < CAL_SAMPLES) begin
                // bias averaging, velocity held
                cal_sum += int'(sample);
                cal_count++;
                if (cal_count >= CAL_SAMPLES)
                    bias = round_half_away(cal_sum, CAL_SAMPLES);
                r.velocity = speed[VEL_W-1:0];
                r.calibrating = 1'b1;
            end
            else begin
                diff = int'(sample) - bias;
                accel = round_half_away(diff * ACCEL_NUM, ACCEL_DEN);
                mag = (accel < 0) ? -accel : accel;
                if (mag < dead_band) begin
                    accel = 0;
                    mag = 0;
                end
                v = speed + longint'(accel) * longint'(ms);
                if (v > VEL_TOP)
                    v = VEL_TOP;
                if (v < VEL_BOTTOM)
                    v = VEL_BOTTOM;
                if (v == VEL_TOP || v == VEL_BOTTOM)
                    saturated++;
                // stationary run, velocity cleared at the limit
                if (mag < still_band)
                    still_count = (still_count + 1) & 'h3FF;
                else
                    still_count = 0;
                if (still_count >= still_limit) begin
                    v = 0;
                    still_count = 0;
                    r.zeroed = 1'b1;
                    zero_events++;
                end
                speed = v;
                av = (v < 0) ? -v : v;
                r.over_limit = (av >= longint'(speed_limit));
                r.velocity = speed[VEL_W-1:0];
            end
            pending_results.push_back(r);
        endfunction

        function void check_result(logic signed [VEL_W-1:0] vel, logic ovl, logic cal,
                                   logic zr);
            vel_result_t want;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result with no item pending: velocity %0d", vel);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (vel !== want.velocity || ovl !== want.over_limit
                || cal !== want.calibrating || zr !== want.zeroed) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch on result %0d: velocity %0d (exp %0d)",
                             checked, vel, want.velocity);
                    $display("  over_limit %b (exp %b) calibrating %b (exp %b) zeroed %b (exp %b)",
                             ovl, want.over_limit, cal, want.calibrating, zr, want.zeroed);
                end
            end
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = REG_DEAD_BAND;
    logic [CFG_DATA_W-1:0]         cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic signed [SAMPLE_W-1:0]    accel_sample = '0;
    logic [MS_W-1:0]               elapsed_ms = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [VEL_W-1:0]       velocity;
    logic                          over_limit;
    logic                          calibrating;
    logic                          zeroed;

    zupt_tracker tracker;
    int          burst_left = 0;
    int          settings_count = 0;
    bit          ready_on = 1'b0;
    int          ready_hold = 0;
    int          cycle_count = 0;

    accel_velocity_integrator_zupt uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .accel_sample (accel_sample),
        .elapsed_ms   (elapsed_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .velocity     (velocity),
        .over_limit   (over_limit),
        .calibrating  (calibrating),
        .zeroed       (zeroed)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, tracker.pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver stall pattern: alternating ready and stall stretches
    always @(posedge clk)
    begin
        if (ready_hold == 0) begin
            ready_on = !ready_on;
            if (ready_on)
                ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 30);
            else
                ready_hold = $urandom_range(1, 25);
        end
        ready_hold--;
        out_ready <= ready_on;
    end

    // result check, sampled half a cycle ahead of the accepting edge
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_result(velocity, over_limit, calibrating, zeroed);
    end

    // one item on the input channel, with burst gaps in front
    task automatic send_item(input int value, input logic [MS_W-1:0] ms);
        logic signed [SAMPLE_W-1:0] s;
        int                         gap;
        if (value > 32767)
            value = 32767;
        if (value < -32768)
            value = -32768;
        s = value[SAMPLE_W-1:0];
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        accel_sample <= s;
        elapsed_ms <= ms;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        tracker.note_sample(s, ms);
    endtask

    // stop sending and wait until every result is back
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        tracker.set_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] db, input logic [CFG_DATA_W-1:0] sb,
                             input logic [CFG_DATA_W-1:0] sl, input logic [CFG_DATA_W-1:0] spl);
        write_reg(REG_DEAD_BAND, db);
        write_reg(REG_STILL_BAND, sb);
        write_reg(REG_STILL_LIMIT, sl);
        write_reg(REG_SPEED_LIMIT, spl);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_count++;
    endtask

    // a run of items of one kind: near the bias, full range or extremes
    task automatic random_run(input int count);
        int              kind;
        int              span;
        int              s;
        int              n;
        logic [MS_W-1:0] ms;
        kind = $urandom_range(0, 9);
        span = (kind < 3) ? 40 : (kind < 6) ? 400 : (kind < 8) ? 4000 : 0;
        for (n = 0; n < count; n++) begin
            if (kind == 9)
                s = ($urandom_range(0, 1) == 0) ? 32767 : -32768;
            else if (span == 0 || $urandom_range(0, 19) == 0)
                s = int'($urandom_range(0, 65535)) - 32768;
            else
                s = tracker.bias + int'($urandom_range(0, 2 * span)) - span;
            if ($urandom_range(0, 7) == 0)
                ms = ($urandom_range(0, 1) == 0) ? 10'd0 : 10'd1023;
            else
                ms = MS_W'($urandom_range(0, 1023));
            send_item(s, ms);
        end
    endtask

    initial
    begin : stimulus
        int partial;
        int s;
        int k;
        int b;
        int left;
        int n;
        tracker = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bias calibration, field extremes first
        send_item(32767, 10'd1023);
        send_item(-32768, 10'd0);
        partial = -1;
        for (k = 0; k < CAL_SAMPLES - 3; k++) begin
            s = -30612 + int'($urandom_range(0, 40)) - 20;
            partial += s;
            send_item(s, MS_W'($urandom_range(0, 1023)));
        end
        send_item(CAL_TARGET - partial, MS_W'($urandom_range(0, 1023)));
        b = tracker.bias;

        // reset register values: rounding, dead band and still band edges
        send_item(b, 10'd0);
        send_item(b + 20, 10'd1023);
        send_item(b - 20, 10'd1023);
        send_item(b + 62, 10'd500);
        send_item(b + 63, 10'd500);
        send_item(b - 62, 10'd500);
        send_item(b - 63, 10'd500);
        send_item(b + 208, 10'd300);
        send_item(b + 209, 10'd300);
        send_item(b - 209, 10'd300);
        send_item(32767, 10'd1023);
        send_item(-32768, 10'd1023);
        send_item(b + 1000, 10'd1);
        send_item(b, 10'd1023);
        settle();

        // widest bands, limit of one, zero speed limit
        configure(31'd1023, 31'd4095, 31'd1, 31'd0);
        send_item(b, 10'd5);
        send_item(32767, 10'd1023);
        send_item(b + 3000, 10'd100);
        settle();

        // zero still limit clears every item
        configure(31'd0, 31'd0, 31'd0, 31'd49000);
        send_item(b + 40, 10'd1000);
        send_item(-32768, 10'd7);
        settle();

        // velocity landing exactly on the speed limit, then beyond it when negative
        configure(31'd0, 31'd0, 31'd1023, 31'd49000);
        send_item(b + 40, 10'd1000);
        send_item(b - 1, 10'd1);
        send_item(b - 40, 10'd1000);
        send_item(b - 40, 10'd1000);
        settle();

        // full-scale items drive the velocity up, then one step back down
        configure(31'd0, 31'd0, 31'd1023, 31'h7FFF_FFFF);
        repeat (23) send_item(32767, 10'd1023);
        send_item(-32768, 10'd1023);
        settle();

        // clear the velocity with a single still item
        configure(31'd77, 31'd4095, 31'd1, 31'd512000);
        send_item(b + 10, 10'd10);
        settle();

        // random items under a range of register settings
        for (k = 0; k < RANDOM_PHASES; k++) begin
            case (k)
                0: configure(CFG_DATA_W'($urandom_range(0, 200)),
                             CFG_DATA_W'($urandom_range(100, 4095)),
                             CFG_DATA_W'($urandom_range(1, 40)),
                             CFG_DATA_W'($urandom_range(0, 100_000_000)));
                1: configure(31'd1023, 31'd4095, 31'd1023, 31'd0);
                2: configure(31'd0, 31'd0, 31'd1, 31'h7FFF_FFFF);
                3: configure(CFG_DATA_W'($urandom_range(0, 1023)),
                             CFG_DATA_W'($urandom_range(0, 4095)),
                             31'd0,
                             CFG_DATA_W'($urandom_range(0, 200_000_000)));
                4: configure(CFG_DATA_W'($urandom_range(0, 100)),
                             CFG_DATA_W'($urandom_range(0, 4095)),
                             CFG_DATA_W'($urandom_range(1, 20)),
                             CFG_DATA_W'($urandom_range(0, 50_000_000)));
                default: configure(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                   CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
            endcase
            left = RANDOM_ITEMS;
            while (left > 0) begin
                n = $urandom_range(1, 40);
                if (n > left)
                    n = left;
                random_run(n);
                left -= n;
            end
            settle();
        end

        tracker.errors += tracker.pending_results.size();
        $display("run covered %0d items (%0d for bias calibration) under %0d register settings",
                 tracker.items, CAL_SAMPLES, settings_count + 1);
        $display("%0d results checked, %0d velocity clears, %0d saturated velocities",
                 tracker.checked, tracker.zero_events, tracker.saturated);
        if (tracker.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

[accel_velocity_integrator_zupt.f]
rtl/avz_pkg.sv
rtl/avz_div.sv
rtl/accel_velocity_integrator_zupt.sv
test/tb_top.sv
